// ===== src/block_decomposed_range_sum_top_assert.svh =====
// Assertion helpers shared by the range sum block.
`ifndef BLOCK_DECOMPOSED_RANGE_SUM_TOP_ASSERT_SVH
`define BLOCK_DECOMPOSED_RANGE_SUM_TOP_ASSERT_SVH

// same-cycle implication
`define BRS_ASSERT_IMPL(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// next-cycle implication
`define BRS_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

// ===== src/brs_pkg.sv =====
package brs_pkg;

   localparam int DEPTH   = 1024;
   localparam int BLOCK   = 32;
   localparam int NBLOCKS = (DEPTH + BLOCK - 1) / BLOCK;

   localparam int DW     = 32;
   localparam int FIELDW = 10;
   localparam int IDXW   = $clog2(DEPTH);
   localparam int OFFW   = $clog2(BLOCK);
   localparam int BW     = (NBLOCKS > 1) ? $clog2(NBLOCKS) : 1;

   localparam int REQ_TDATA_W = 64;
   localparam int RSP_TDATA_W = 32;

   localparam logic OP_SET   = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef struct packed {
      logic              op;
      logic [FIELDW-1:0] position;
      logic [DW-1:0]     new_value;
      logic [FIELDW-1:0] left_index;
      logic [FIELDW-1:0] right_index;
   } item_type;

   typedef struct packed {
      logic [DW-1:0] range_sum;
      logic          bad_range;
   } result_type;

   typedef struct packed {
      logic            e_en;
      logic            e_we;
      logic [IDXW-1:0] e_addr;
      logic [DW-1:0]   e_wdata;
      logic            b_en;
      logic            b_we;
      logic [BW-1:0]   b_addr;
      logic [DW-1:0]   b_wdata;
   } mem_cmd_type;

   function automatic logic [BW-1:0] block_of(input logic [IDXW-1:0] idx);
      return BW'(32'(idx) >> OFFW);
   endfunction

   function automatic logic [IDXW-1:0] block_base(input logic [BW-1:0] blk);
      return IDXW'(32'(blk) << OFFW);
   endfunction

endpackage

// ===== src/brs_store.sv =====
module brs_store (
   input  logic                  clock,
   input  brs_pkg::mem_cmd_type  cmd,
   output logic [brs_pkg::DW-1:0] e_rdata,
   output logic [brs_pkg::DW-1:0] b_rdata
);

   logic [brs_pkg::DW-1:0] elem_mem [brs_pkg::DEPTH];
   logic [brs_pkg::DW-1:0] bsum_mem [brs_pkg::NBLOCKS];
   logic [brs_pkg::DW-1:0] e_rdata_ff;
   logic [brs_pkg::DW-1:0] b_rdata_ff;

   always_ff @(posedge clock) begin
      if (cmd.e_en) begin
         if (cmd.e_we) begin
            elem_mem[cmd.e_addr] <= cmd.e_wdata;
         end else begin
            e_rdata_ff <= elem_mem[cmd.e_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.b_en) begin
         if (cmd.b_we) begin
            bsum_mem[cmd.b_addr] <= cmd.b_wdata;
         end else begin
            b_rdata_ff <= bsum_mem[cmd.b_addr];
         end
      end
   end

   assign e_rdata = e_rdata_ff;
   assign b_rdata = b_rdata_ff;

endmodule

// ===== src/brs_seq.sv =====
`include "block_decomposed_range_sum_top_assert.svh"

module brs_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  brs_pkg::item_type      item,
   output brs_pkg::mem_cmd_type   cmd,
   input  logic [brs_pkg::DW-1:0] e_rdata,
   input  logic [brs_pkg::DW-1:0] b_rdata,
   output logic                   res_valid,
   input  logic                   res_ready,
   output brs_pkg::result_type    res
);

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_SET_WR = 3'd2;
   localparam logic [2:0] S_QUERY  = 3'd3;
   localparam logic [2:0] S_EMIT   = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [brs_pkg::IDXW-1:0] clr_ff, clr_in;
   logic e_act_ff, e_act_in, k_act_ff, k_act_in;
   logic e_pend_ff, e_pend_in, k_pend_ff, k_pend_in;

   logic [brs_pkg::IDXW-1:0] pos_ff, pos_in;
   logic [brs_pkg::DW-1:0]   val_ff, val_in;
   logic [brs_pkg::IDXW-1:0] e_ff, e_in;
   logic [brs_pkg::IDXW-1:0] hi_ff, hi_in;
   logic [brs_pkg::BW-1:0]   bh_ff, bh_in;
   logic [brs_pkg::BW-1:0]   k_ff, k_in;
   logic [brs_pkg::DW-1:0]   acc_ff, acc_in;
   logic                     bad_ff, bad_in;

   // decoded query bounds of the incoming word
   logic [brs_pkg::IDXW-1:0] q_pos, q_lo, q_hi;
   logic [brs_pkg::BW-1:0]   q_bl, q_bh;
   logic                     e_tail_end;

   assign q_pos = brs_pkg::IDXW'(32'(item.position));
   assign q_lo  = brs_pkg::IDXW'(32'(item.left_index));
   assign q_hi  = (32'(item.right_index) > brs_pkg::DEPTH - 1) ?
                  brs_pkg::IDXW'(brs_pkg::DEPTH - 1) :
                  brs_pkg::IDXW'(32'(item.right_index));
   assign q_bl  = brs_pkg::block_of(q_lo);
   assign q_bh  = brs_pkg::block_of(q_hi);

   // last element of a block other than the right one: jump to the right block
   assign e_tail_end = ((32'(e_ff) & (brs_pkg::BLOCK - 1)) == brs_pkg::BLOCK - 1) &&
                       (brs_pkg::block_of(e_ff) != bh_ff);

   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      e_act_in  = e_act_ff;
      k_act_in  = k_act_ff;
      e_pend_in = 1'b0;
      k_pend_in = 1'b0;
      pos_in    = pos_ff;
      val_in    = val_ff;
      e_in      = e_ff;
      hi_in     = hi_ff;
      bh_in     = bh_ff;
      k_in      = k_ff;
      acc_in    = acc_ff;
      bad_in    = bad_ff;
      cmd       = '0;
      req_ready = 1'b0;
      res_valid = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            cmd.e_en   = 1'b1;
            cmd.e_we   = 1'b1;
            cmd.e_addr = clr_ff;
            if (32'(clr_ff) < brs_pkg::NBLOCKS) begin
               cmd.b_en   = 1'b1;
               cmd.b_we   = 1'b1;
               cmd.b_addr = brs_pkg::BW'(32'(clr_ff));
            end
            if (clr_ff == brs_pkg::IDXW'(brs_pkg::DEPTH - 1)) begin
               state_in = S_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (item.op == brs_pkg::OP_SET) begin
                  if (32'(item.position) < brs_pkg::DEPTH) begin
                     cmd.e_en   = 1'b1;
                     cmd.e_addr = q_pos;
                     cmd.b_en   = 1'b1;
                     cmd.b_addr = brs_pkg::block_of(q_pos);
                     pos_in     = q_pos;
                     val_in     = item.new_value;
                     state_in   = S_SET_WR;
                  end
               end else if (item.left_index > item.right_index) begin
                  acc_in   = '0;
                  bad_in   = 1'b1;
                  state_in = S_EMIT;
               end else if (32'(item.left_index) >= brs_pkg::DEPTH) begin
                  acc_in   = '0;
                  bad_in   = 1'b0;
                  state_in = S_EMIT;
               end else begin
                  e_in     = q_lo;
                  hi_in    = q_hi;
                  bh_in    = q_bh;
                  k_in     = q_bl + 1'b1;
                  e_act_in = 1'b1;
                  k_act_in = ({1'b0, q_bl} + 1'b1) < {1'b0, q_bh};
                  acc_in   = '0;
                  bad_in   = 1'b0;
                  state_in = S_QUERY;
               end
            end
         end
         S_SET_WR: begin
            cmd.e_en    = 1'b1;
            cmd.e_we    = 1'b1;
            cmd.e_addr  = pos_ff;
            cmd.e_wdata = val_ff;
            cmd.b_en    = 1'b1;
            cmd.b_we    = 1'b1;
            cmd.b_addr  = brs_pkg::block_of(pos_ff);
            cmd.b_wdata = b_rdata + val_ff - e_rdata;
            state_in    = S_IDLE;
         end
         S_QUERY: begin
            if (e_act_ff) begin
               cmd.e_en   = 1'b1;
               cmd.e_addr = e_ff;
               if (e_ff == hi_ff) begin
                  e_act_in = 1'b0;
               end else if (e_tail_end) begin
                  e_in = brs_pkg::block_base(bh_ff);
               end else begin
                  e_in = e_ff + 1'b1;
               end
            end
            if (k_act_ff) begin
               cmd.b_en   = 1'b1;
               cmd.b_addr = k_ff;
               if (({1'b0, k_ff} + 1'b1) == {1'b0, bh_ff}) begin
                  k_act_in = 1'b0;
               end else begin
                  k_in = k_ff + 1'b1;
               end
            end
            e_pend_in = e_act_ff;
            k_pend_in = k_act_ff;
            acc_in = acc_ff + (e_pend_ff ? e_rdata : '0) + (k_pend_ff ? b_rdata : '0);
            if (!e_act_ff && !k_act_ff && !e_pend_ff && !k_pend_ff) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         clr_ff    <= '0;
         e_act_ff  <= 1'b0;
         k_act_ff  <= 1'b0;
         e_pend_ff <= 1'b0;
         k_pend_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         e_act_ff  <= e_act_in;
         k_act_ff  <= k_act_in;
         e_pend_ff <= e_pend_in;
         k_pend_ff <= k_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      val_ff <= val_in;
      e_ff   <= e_in;
      hi_ff  <= hi_in;
      bh_ff  <= bh_in;
      k_ff   <= k_in;
      acc_ff <= acc_in;
      bad_ff <= bad_in;
   end

   assign res.range_sum = acc_ff;
   assign res.bad_range = bad_ff;

   `BRS_ASSERT_IMPL(a_elem_walk_bound, clock, reset, e_act_ff, e_ff <= hi_ff,
                    "element walk passed the right index")
   `BRS_ASSERT_IMPL(a_blk_walk_bound, clock, reset, k_act_ff, k_ff < bh_ff,
                    "block walk reached the right block")
   `BRS_ASSERT_IMPL(a_set_after_idle, clock, reset, state_ff == S_SET_WR,
                    $past(state_ff) == S_IDLE, "write-back without a read")
   `BRS_ASSERT_IMPL(a_query_no_write, clock, reset, state_ff == S_QUERY,
                    !cmd.e_we && !cmd.b_we, "memory write during a query")
   `BRS_ASSERT_NEXT(a_emit_holds, clock, reset, res_valid && !res_ready,
                    res_valid && $stable(acc_ff) && $stable(bad_ff),
                    "pending result changed before it was taken")

endmodule

// ===== src/block_decomposed_range_sum_top.sv =====
// Range sums over a 1024-entry array of signed 32-bit elements, kept with one
// running sum per 32-element block.
// req channel: one word per operation. tuser = opcode (0 set, 1 query).
// A set word writes new_value at position and produces no response; it reads
// the old element and block sum, then writes both back.
// A query word returns one rsp word with the wrapped sum of
// left_index..right_index; a reversed range gives zero with bad_range set.
// A query walks the two partial block tails through the element memory while
// the covered block sums stream from the block-sum memory in parallel, one
// read per memory per cycle; the sum then waits in S_EMIT until the output
// register takes it, and the sequencer returns to idle for the next word.
// One operation is in flight at a time; req_tready is high only while the
// sequencer is idle.
// After reset a clearing pass writes zero to every entry, with req_tready low.
// A stalled rsp_tready holds the response in the output register; set words
// are still taken until one more query finishes, which then waits in the
// sequencer with req_tready low.
module block_decomposed_range_sum_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // position[9:0], new_value[41:10], left_index[51:42], right_index[61:52]
   input  logic [brs_pkg::REQ_TDATA_W-1:0] req_tdata,
   // opcode
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // range_sum[31:0]
   output logic [brs_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // bad_range
   output logic                            rsp_tuser
);

   brs_pkg::item_type     item;
   brs_pkg::mem_cmd_type  cmd;
   brs_pkg::result_type   res;
   logic [brs_pkg::DW-1:0] e_rdata, b_rdata;
   logic                  res_valid, res_ready;

   logic                 rsp_valid_ff, rsp_valid_in;
   brs_pkg::result_type  rsp_ff, rsp_in;

   assign item.op          = req_tuser;
   assign item.position    = req_tdata[9:0];
   assign item.new_value   = req_tdata[41:10];
   assign item.left_index  = req_tdata[51:42];
   assign item.right_index = req_tdata[61:52];

   brs_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .item      (item),
      .cmd       (cmd),
      .e_rdata   (e_rdata),
      .b_rdata   (b_rdata),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res)
   );

   brs_store u_store (
      .clock   (clock),
      .cmd     (cmd),
      .e_rdata (e_rdata),
      .b_rdata (b_rdata)
   );

   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_ready) begin
         rsp_valid_in = res_valid;
         if (res_valid) begin
            rsp_in = res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = brs_pkg::RSP_TDATA_W'(rsp_ff.range_sum);
   assign rsp_tuser  = rsp_ff.bad_range;

endmodule
